/* design/ncps_pkg.sv */
// Package for the normalized cross-power spectrum block.
// Holds the default widths shared by the top level.
// No dependencies.
package ncps_pkg;
  localparam int unsigned CompWidthDef = 16;
  localparam int unsigned OutFracDef   = 14;
endpackage

/* design/normalized_cross_power_spectrum_top.sv */
// Normalized cross-power spectrum: a*conj(b) / (|a|*|b|) in signed Q1.(OUT_FRAC_BITS).
// Start travels through the product, sum, square, setup and quotient-bit stages and the output register to done.
// Throughput: one word per cycle; busy stays low and the pipeline never stalls.
// Depth is set by the restoring root-quotient search, one quotient bit per stage.
// Reset (rst, synchronous, active high) clears only the valid bits of the pipeline.
// Depends on ncps_pkg.
module normalized_cross_power_spectrum_top #(
  parameter int unsigned COMPONENT_WIDTH = ncps_pkg::CompWidthDef,
  parameter int unsigned OUT_FRAC_BITS   = ncps_pkg::OutFracDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] a_real,
  input  logic signed [COMPONENT_WIDTH-1:0] a_imag,
  input  logic signed [COMPONENT_WIDTH-1:0] b_real,
  input  logic signed [COMPONENT_WIDTH-1:0] b_imag,
  output logic                              done,
  output logic signed [OUT_FRAC_BITS+1:0]   out_real,
  output logic signed [OUT_FRAC_BITS+1:0]   out_imag,
  output logic                              zero_magnitude
);
  import ncps_pkg::*;

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned F  = OUT_FRAC_BITS;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = 2 * CW + 1;
  localparam int unsigned MW = 2 * CW;
  localparam int unsigned QW = 4 * CW;
  localparam int unsigned DW = 4 * CW + 1;
  localparam int unsigned WW = 4 * CW + 2 * F + 3;
  localparam int unsigned NB = F + 1;
  localparam int unsigned OW = F + 2;
  localparam logic signed [OW-1:0] OneVal = OW'(1) <<< F;

  assign busy = 1'b0;

  // stage 1: partial products
  logic                 v1;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    p_rr <= a_real * b_real;
    p_ii <= a_imag * b_imag;
    p_ir <= a_imag * b_real;
    p_ri <= a_real * b_imag;
  end

  // stage 2: signed sums to sign-magnitude
  logic                 v2, s2_r, s2_i, z2;
  logic        [MW-1:0] m2_r, m2_i;
  logic signed [SW-1:0] sum_r, sum_i;

  always_comb begin
    sum_r = SW'(p_rr) + SW'(p_ii);
    sum_i = SW'(p_ir) - SW'(p_ri);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    s2_r <= sum_r[SW-1];
    s2_i <= sum_i[SW-1];
    m2_r <= sum_r[SW-1] ? MW'(-sum_r) : MW'(sum_r);
    m2_i <= sum_i[SW-1] ? MW'(-sum_i) : MW'(sum_i);
    z2   <= (sum_r == '0) && (sum_i == '0);
  end

  // stage 3: squares
  logic          v3, s3_r, s3_i, z3;
  logic [QW-1:0] sq_r, sq_i;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s3_r <= s2_r;
    s3_i <= s2_i;
    z3   <= z2;
    sq_r <= m2_r * m2_r;
    sq_i <= m2_i * m2_i;
  end

  // stage 4 and bit stages: remainder = comp^2 * 2^2F - q^2 * den, prod = q * den
  logic          vp  [0:NB];
  logic          sp_r[0:NB];
  logic          sp_i[0:NB];
  logic          zp  [0:NB];
  logic [WW-1:0] den [0:NB];
  logic [WW-1:0] rm_r[0:NB];
  logic [WW-1:0] rm_i[0:NB];
  logic [WW-1:0] pd_r[0:NB];
  logic [WW-1:0] pd_i[0:NB];
  logic [NB-1:0] q_r [0:NB];
  logic [NB-1:0] q_i [0:NB];

  always_ff @(posedge clk) begin
    if (rst) vp[0] <= 1'b0;
    else vp[0] <= v3;
    sp_r[0] <= s3_r;
    sp_i[0] <= s3_i;
    zp[0]   <= z3;
    den[0]  <= WW'(DW'(sq_r) + DW'(sq_i));
    rm_r[0] <= WW'(sq_r) << (2 * F);
    rm_i[0] <= WW'(sq_i) << (2 * F);
    pd_r[0] <= '0;
    pd_i[0] <= '0;
    q_r[0]  <= '0;
    q_i[0]  <= '0;
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int unsigned B = F - k;
    logic [WW-1:0] t_r, t_i;
    logic          ok_r, ok_i;

    always_comb begin
      t_r  = (pd_r[k] << (B + 1)) + (den[k] << (2 * B));
      t_i  = (pd_i[k] << (B + 1)) + (den[k] << (2 * B));
      ok_r = t_r <= rm_r[k];
      ok_i = t_i <= rm_i[k];
    end

    always_ff @(posedge clk) begin
      if (rst) vp[k+1] <= 1'b0;
      else vp[k+1] <= vp[k];
      sp_r[k+1] <= sp_r[k];
      sp_i[k+1] <= sp_i[k];
      zp[k+1]   <= zp[k];
      den[k+1]  <= den[k];
      rm_r[k+1] <= ok_r ? rm_r[k] - t_r : rm_r[k];
      rm_i[k+1] <= ok_i ? rm_i[k] - t_i : rm_i[k];
      pd_r[k+1] <= ok_r ? pd_r[k] + (den[k] << B) : pd_r[k];
      pd_i[k+1] <= ok_i ? pd_i[k] + (den[k] << B) : pd_i[k];
      q_r[k+1]  <= q_r[k] | (NB'(ok_r) << B);
      q_i[k+1]  <= q_i[k] | (NB'(ok_i) << B);
    end
  end

  // output stage: apply sign, force zero on a null product
  logic [OW-1:0] u_r, u_i;

  always_comb begin
    u_r = {1'b0, q_r[NB]};
    u_i = {1'b0, q_i[NB]};
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vp[NB];
    zero_magnitude <= zp[NB];
    out_real <= zp[NB] ? '0 : (sp_r[NB] ? -u_r : u_r);
    out_imag <= zp[NB] ? '0 : (sp_i[NB] ? -u_i : u_i);
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    done && zero_magnitude |-> out_real == '0 && out_imag == '0)
    else $error("nonzero result on null product");
  a_range_r: assert property (@(posedge clk) disable iff (rst)
    done |-> out_real <= OneVal && out_real >= -OneVal)
    else $error("out_real out of unit range");
  a_range_i: assert property (@(posedge clk) disable iff (rst)
    done |-> out_imag <= OneVal && out_imag >= -OneVal)
    else $error("out_imag out of unit range");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vp[0] |-> ##(NB + 1) done)
    else $error("word lost in pipeline");
endmodule
